// File: hdl/udiv128_pkg.sv
// shared types and widths for the 128-bit pipelined restoring divider
// no dependencies
`timescale 1ns / 1ps

package udiv128_pkg;

    // width of each operand half on the ports
    localparam int WORD_BITS    = 64;
    // width of the full operand as seen on the ports
    localparam int FULL_BITS    = 2 * WORD_BITS;
    // operand width the divider works at, 8 .. 128
    localparam int OPERAND_BITS = 128;
    // shifted partial remainder: one extra bit unless it would pass the full width
    localparam int SHIFT_BITS   = (OPERAND_BITS < FULL_BITS) ? OPERAND_BITS + 1 : FULL_BITS;

    // one pipeline stage's view of an item in flight
    // nq holds the dividend bits still to come on top and the quotient bits so far below
    typedef struct packed {
        logic                    vld;
        logic [OPERAND_BITS-1:0] rem;
        logic [OPERAND_BITS-1:0] nq;
        logic [OPERAND_BITS-1:0] dvs;
    } lane_t;

endpackage

// File: hdl/unsigned_divide_128_core.sv
// top level of the pipelined 128-bit unsigned restoring divider
// depends on udiv128_pkg and udiv128_step
`timescale 1ns / 1ps

// unsigned 128-bit divider, quotient only
//
// input channel s_*: dividend and divisor, each as low and high 64-bit halves,
// taken when s_valid and s_ready are both high
// result channel m_*: quotient as low and high halves, handed over when
// m_valid and m_ready are both high; one result per item, in order
//
// one quotient bit is resolved per pipeline stage, so there are OPERAND_BITS
// stages (128); each stage holds one 128-bit subtract and compare
// throughput: one item per cycle while the skid entry is empty, set by the
// one-bit-per-stage pipeline
//
// a zero divisor gives an all-ones quotient
//
// stalls: a one-entry skid register sits behind the last stage; when the
// receiver holds m_ready low the finished item moves there as the pipe
// advances, then the whole pipe freezes (s_ready low) until the skid entry
// is taken; nothing is lost or repeated
//
// reset (aresetn low, synchronous) drops every item in flight and the
// skid entry; s_ready is high right after reset
module unsigned_divide_128_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [udiv128_pkg::WORD_BITS-1:0]  s_dividend_low,
    input  logic [udiv128_pkg::WORD_BITS-1:0]  s_dividend_high,
    input  logic [udiv128_pkg::WORD_BITS-1:0]  s_divisor_low,
    input  logic [udiv128_pkg::WORD_BITS-1:0]  s_divisor_high,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [udiv128_pkg::WORD_BITS-1:0]  m_quotient_low,
    output logic [udiv128_pkg::WORD_BITS-1:0]  m_quotient_high
);
    import udiv128_pkg::*;

    // full-width operands as they arrive
    logic [FULL_BITS-1:0] dividend_full;
    logic [FULL_BITS-1:0] divisor_full;

    // lane[0] is the entering item, lane[k+1] the register after step k
    lane_t lane [0:OPERAND_BITS];

    // pipe advance: frozen only while the skid entry is occupied
    logic pipe_en;

    // skid entry behind the last stage
    logic                    skid_full_reg;
    logic                    skid_full_next;
    logic [OPERAND_BITS-1:0] skid_q_reg;

    logic [OPERAND_BITS-1:0] out_q;
    logic [FULL_BITS-1:0]    out_q_full;
    logic                    last_vld;

    assign dividend_full = {s_dividend_high, s_dividend_low};
    assign divisor_full  = {s_divisor_high, s_divisor_low};

    assign pipe_en = ~skid_full_reg;
    assign s_ready = pipe_en;

    // bits above the operand width are ignored; remainder starts at zero
    assign lane[0].vld = s_valid;
    assign lane[0].rem = '0;
    assign lane[0].nq  = dividend_full[OPERAND_BITS-1:0];
    assign lane[0].dvs = divisor_full[OPERAND_BITS-1:0];

    genvar k;
    generate
        for (k = 0; k < OPERAND_BITS; k++) begin : g_step
            udiv128_step u_step (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .en       (pipe_en),
                .lane_in  (lane[k]),
                .lane_out (lane[k+1])
            );
        end
    endgenerate

    assign last_vld = lane[OPERAND_BITS].vld;

    // skid fills when the last stage holds an item the receiver does not take,
    // and drains when the receiver takes it
    always_comb begin
        skid_full_next = skid_full_reg;
        if (skid_full_reg) begin
            if (m_ready) begin
                skid_full_next = 1'b0;
            end
        end else if (last_vld && !m_ready) begin
            skid_full_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_full_reg <= 1'b0;
        end else begin
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_full_reg) begin
            skid_q_reg <= lane[OPERAND_BITS].nq;
        end
    end

    // the skid entry is older than anything in the last stage
    assign m_valid    = skid_full_reg | last_vld;
    assign out_q      = skid_full_reg ? skid_q_reg : lane[OPERAND_BITS].nq;
    assign out_q_full = FULL_BITS'(out_q);

    assign m_quotient_low  = out_q_full[WORD_BITS-1:0];
    assign m_quotient_high = out_q_full[FULL_BITS-1:WORD_BITS];

endmodule

// File: hdl/udiv128_step.sv
// one restoring division step with its output register
// depends on udiv128_pkg
`timescale 1ns / 1ps

module udiv128_step (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  udiv128_pkg::lane_t lane_in,
    output udiv128_pkg::lane_t lane_out
);
    import udiv128_pkg::*;

    logic [SHIFT_BITS-1:0]   shifted;
    logic [SHIFT_BITS-1:0]   dvs_ext;
    logic [SHIFT_BITS:0]     diff;
    logic                    ge;
    logic [OPERAND_BITS-1:0] rem_next;
    logic [OPERAND_BITS-1:0] nq_next;
    lane_t                   lane_reg;

    // shift the remainder up and bring in the next dividend bit
    assign shifted  = {lane_in.rem[SHIFT_BITS-2:0], lane_in.nq[OPERAND_BITS-1]};
    assign dvs_ext  = SHIFT_BITS'(lane_in.dvs);
    assign diff     = {1'b0, shifted} - {1'b0, dvs_ext};
    assign ge       = ~diff[SHIFT_BITS];
    assign rem_next = ge ? diff[OPERAND_BITS-1:0] : shifted[OPERAND_BITS-1:0];
    assign nq_next  = {lane_in.nq[OPERAND_BITS-2:0], ge};

    // only the valid bit is cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_reg.vld <= 1'b0;
        end else if (en) begin
            lane_reg.vld <= lane_in.vld;
            lane_reg.rem <= rem_next;
            lane_reg.nq  <= nq_next;
            lane_reg.dvs <= lane_in.dvs;
        end
    end

    assign lane_out = lane_reg;

endmodule

// File: hdl/udiv128_chk.sv
// port-level checks for unsigned_divide_128_core, attached by bind
// depends on udiv128_pkg
`timescale 1ns / 1ps

module udiv128_chk (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic [udiv128_pkg::WORD_BITS-1:0]  s_dividend_low,
    input logic [udiv128_pkg::WORD_BITS-1:0]  s_dividend_high,
    input logic [udiv128_pkg::WORD_BITS-1:0]  s_divisor_low,
    input logic [udiv128_pkg::WORD_BITS-1:0]  s_divisor_high,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [udiv128_pkg::WORD_BITS-1:0]  m_quotient_low,
    input logic [udiv128_pkg::WORD_BITS-1:0]  m_quotient_high
);
    import udiv128_pkg::*;

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its value
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_quotient_low) && $stable(m_quotient_high))
        else $error("result changed while stalled");

    // the input side only closes while a finished item is waiting
    a_closed_has_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input blocked with no result offered");

    // handing over a result always reopens the input side
    a_reopen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> s_ready)
        else $error("input still blocked after result taken");

endmodule

bind unsigned_divide_128_core udiv128_chk u_udiv128_chk (.*);

// File: tb/udiv128_quotient_checker.sv
// scoreboard for the 128-bit unsigned divider: predicts each quotient and checks the result channel
// depends on udiv128_pkg
`timescale 1ns / 1ps

module udiv128_quotient_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [udiv128_pkg::WORD_BITS-1:0]  s_dividend_low,
    input  logic [udiv128_pkg::WORD_BITS-1:0]  s_dividend_high,
    input  logic [udiv128_pkg::WORD_BITS-1:0]  s_divisor_low,
    input  logic [udiv128_pkg::WORD_BITS-1:0]  s_divisor_high,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic [udiv128_pkg::WORD_BITS-1:0]  m_quotient_low,
    input  logic [udiv128_pkg::WORD_BITS-1:0]  m_quotient_high,
    output int                                 failures,
    output int                                 results_pending,
    output int                                 results_checked
);

    import udiv128_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [WORD_BITS-1:0] quotient_high;
        logic [WORD_BITS-1:0] quotient_low;
    } quotient_t;

    quotient_t quotients_due[$];
    quotient_t due;

    // long division from the top bit down; the remainder stays at the full
    // port width, so a carry out of the shift is dropped
    function automatic quotient_t divide_restoring(
        input logic [FULL_BITS-1:0] dividend,
        input logic [FULL_BITS-1:0] divisor
    );
        int                 span;
        logic [FULL_BITS-1:0] keep;
        logic [FULL_BITS-1:0] num;
        logic [FULL_BITS-1:0] den;
        logic [FULL_BITS-1:0] rem;
        logic [FULL_BITS-1:0] quo;
        quotient_t          res;
        span = OPERAND_BITS;
        if (span < 1) span = 1;
        if (span > FULL_BITS) span = FULL_BITS;
        keep = (span >= FULL_BITS) ? '1 : ((FULL_BITS'(1) << span) - 1'b1);
        num = dividend & keep;
        den = divisor & keep;
        rem = '0;
        quo = '0;
        for (int pos = span - 1; pos >= 0; pos--) begin
            rem = {rem[FULL_BITS-2:0], num[pos]};
            if (rem >= den) begin
                rem = rem - den;
                quo[pos] = 1'b1;
            end
        end
        quo = quo & keep;
        res.quotient_high = quo[FULL_BITS-1:WORD_BITS];
        res.quotient_low  = quo[WORD_BITS-1:0];
        return res;
    endfunction

    // at most one failure can arise per cycle, so the registered count is
    // good enough to limit the reports
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                quotients_due.push_back(divide_restoring({s_dividend_high, s_dividend_low},
                                                         {s_divisor_high, s_divisor_low}));
            end
            if (m_valid && m_ready) begin
                if (quotients_due.size() == 0) begin
                    if (failures < MAX_REPORTS) begin
                        $display("%0t: result item with no division pending: %h_%h", $realtime,
                                 m_quotient_high, m_quotient_low);
                    end
                    failures <= failures + 1;
                end else begin
                    due = quotients_due.pop_front();
                    if (m_quotient_high !== due.quotient_high ||
                        m_quotient_low !== due.quotient_low) begin
                        if (failures < MAX_REPORTS) begin
                            $display("%0t: quotient mismatch: expected %h_%h, got %h_%h",
                                     $realtime, due.quotient_high, due.quotient_low,
                                     m_quotient_high, m_quotient_low);
                        end
                        failures <= failures + 1;
                    end
                    results_checked <= results_checked + 1;
                end
            end
            results_pending <= quotients_due.size();
        end
    end

endmodule

// File: tb/unsigned_divide_128_core_test.sv
// stimulus and verdict for the pipelined 128-bit unsigned divider
// depends on udiv128_pkg, unsigned_divide_128_core and udiv128_quotient_checker
`timescale 1ns / 1ps

module unsigned_divide_128_core_test;

    import udiv128_pkg::*;

    localparam int RESET_CYCLES = 12;
    // output hold well beyond the pipe depth plus the skid entry
    localparam int HOLD_CYCLES  = 400;
    // quiet time after the last result: a bit more than the pipe latency
    localparam int TAIL_CYCLES  = 200;
    localparam int CYCLE_LIMIT  = 200000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [WORD_BITS-1:0] s_dividend_low;
    logic [WORD_BITS-1:0] s_dividend_high;
    logic [WORD_BITS-1:0] s_divisor_low;
    logic [WORD_BITS-1:0] s_divisor_high;
    logic                 m_valid;
    logic                 m_ready;
    logic [WORD_BITS-1:0] m_quotient_low;
    logic [WORD_BITS-1:0] m_quotient_high;

    int failures;
    int results_pending;
    int results_checked;

    // knobs for the sender and the receiver processes
    bit sender_gaps;
    bit receiver_steady;
    bit hold_request;

    int cycle_count;
    int directed_count;
    int random_count;
    int zero_divisor_count;
    int drain_count;

    unsigned_divide_128_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_dividend_low  (s_dividend_low),
        .s_dividend_high (s_dividend_high),
        .s_divisor_low   (s_divisor_low),
        .s_divisor_high  (s_divisor_high),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_quotient_low  (m_quotient_low),
        .m_quotient_high (m_quotient_high)
    );

    udiv128_quotient_checker checker_inst (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_dividend_low  (s_dividend_low),
        .s_dividend_high (s_dividend_high),
        .s_divisor_low   (s_divisor_low),
        .s_divisor_high  (s_divisor_high),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_quotient_low  (m_quotient_low),
        .m_quotient_high (m_quotient_high),
        .failures        (failures),
        .results_pending (results_pending),
        .results_checked (results_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog: a hung handshake ends the run here
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // receiver: random back-pressure, a steady-ready mode, and one long hold
    // that is counted out here so the sender can keep pushing meanwhile
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_request) begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (receiver_steady) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 30);
            end
            @(posedge aclk);
        end
    end

    function automatic logic [FULL_BITS-1:0] random_wide();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // random value of at most the given bit length, 0 .. 128
    function automatic logic [FULL_BITS-1:0] random_bits(input int unsigned bits);
        logic [FULL_BITS-1:0] raw;
        raw = random_wide();
        if (bits == 0) return '0;
        return raw >> (FULL_BITS - bits);
    endfunction

    // one item: optional idle cycles, then hold valid until s_ready takes it
    task automatic offer_division(input logic [FULL_BITS-1:0] dividend,
                                  input logic [FULL_BITS-1:0] divisor);
        while (sender_gaps && $urandom_range(99) < 30) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_dividend_low  <= dividend[WORD_BITS-1:0];
        s_dividend_high <= dividend[FULL_BITS-1:WORD_BITS];
        s_divisor_low   <= divisor[WORD_BITS-1:0];
        s_divisor_high  <= divisor[FULL_BITS-1:WORD_BITS];
        do @(posedge aclk); while (!s_ready);
        if (divisor == '0) zero_divisor_count++;
    endtask

    task automatic offer_directed(input logic [FULL_BITS-1:0] dividend,
                                  input logic [FULL_BITS-1:0] divisor);
        offer_division(dividend, divisor);
        directed_count++;
    endtask

    // random mix: full-width pairs give tiny quotients, short divisors give
    // wide ones; random-length pairs, zero divisors, near-equal pairs and
    // pairs with the top bit set in both operands are mixed in
    task automatic offer_random(input int count);
        int                   pick;
        logic [FULL_BITS-1:0] num;
        logic [FULL_BITS-1:0] den;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            num = random_wide();
            den = random_wide();
            if (pick < 30) begin
                // both operands full width
            end else if (pick < 55) begin
                den = random_bits($urandom_range(128, 1));
            end else if (pick < 70) begin
                den = random_bits($urandom_range(64, 1));
            end else if (pick < 82) begin
                num = random_bits($urandom_range(128, 1));
                den = random_bits($urandom_range(128, 1));
            end else if (pick < 87) begin
                den = '0;
            end else if (pick < 93) begin
                den = num - random_bits($urandom_range(4, 0)) + random_bits($urandom_range(2, 0));
            end else begin
                num[FULL_BITS-1] = 1'b1;
                den[FULL_BITS-1] = 1'b1;
            end
            offer_division(num, den);
            random_count++;
        end
    endtask

    // sender pause: nothing offered until every expected quotient is back
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_pending != 0);
        drain_count++;
    endtask

    initial begin
        sender_gaps     = 1'b1;
        receiver_steady = 1'b0;
        hold_request    = 1'b0;

        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_dividend_low  <= '0;
        s_dividend_high <= '0;
        s_divisor_low   <= '0;
        s_divisor_high  <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners
        // zero divisor, with zero and full dividends
        offer_directed('0, '0);
        offer_directed('1, '0);
        // unit divisor and trivial dividends
        offer_directed('0, 128'd1);
        offer_directed('1, 128'd1);
        offer_directed(128'd1, '1);
        // equal and nearly equal operands at full width, then the top bit divided by one
        offer_directed('1, '1);
        offer_directed('1 - 128'd1, '1);
        offer_directed({1'b1, 127'd0}, {1'b1, 127'd0});
        offer_directed({1'b1, 127'd0}, 128'd1);
        // divisors with the top bit or the bit below it set
        offer_directed('1, {1'b1, 127'd1});
        offer_directed('1, {1'b1, 127'd0});
        offer_directed('1, {2'b01, {126{1'b1}}});
        offer_directed({1'b1, 127'd0} | 128'd12345, {2'b01, 126'd0});
        // crossings between the two halves
        offer_directed({64'd1, 64'd0}, {64'd0, {64{1'b1}}});
        offer_directed({64'd0, {64{1'b1}}}, {64'd0, 64'd1});
        offer_directed('1, {64'd1, 64'd0});
        offer_directed({{64{1'b1}}, 64'd0}, {64'd1, 64'd0});
        offer_directed({64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000},
                       {64'd0, {64{1'b1}}});
        // alternating patterns and small odd divisors
        offer_directed({64{2'b10}}, {64{2'b01}});
        offer_directed({64{2'b01}}, 128'd3);
        offer_directed('1, 128'd3);
        offer_directed(128'd12345, 128'd7);
        offer_directed(128'd6, 128'd7);
        wait_for_drain();

        // random items with idling on both sides
        offer_random(400);
        wait_for_drain();

        // long output hold while items keep coming: the pipe fills, s_ready
        // drops and the sender blocks until the hold runs out
        sender_gaps  = 1'b0;
        hold_request = 1'b1;
        offer_random(250);
        wait_for_drain();

        // a long stretch with no idling at all on either side
        receiver_steady = 1'b1;
        offer_random(300);

        // back to random idling for the rest
        sender_gaps     = 1'b1;
        receiver_steady = 1'b0;
        offer_random(200);
        wait_for_drain();

        // let any stray result show up before the verdict
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("ran %0d directed and %0d random divisions (%0d by zero), %0d quotients checked",
                 directed_count, random_count, zero_divisor_count, results_checked);
        $display("stress: one %0d-cycle output hold with the input stalled, %0d full drains",
                 HOLD_CYCLES, drain_count);
        if (failures == 0 && results_pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: unsigned_divide_128_core.f
hdl/udiv128_pkg.sv
hdl/udiv128_step.sv
hdl/unsigned_divide_128_core.sv
hdl/udiv128_chk.sv
tb/udiv128_quotient_checker.sv
tb/unsigned_divide_128_core_test.sv
